>>> rtl/sta_pkg.sv
// Shared types, register indexes and alarm codes of the sensor threshold alarm.
`timescale 1ns / 1ps

package sta_pkg;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_MUTE   = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PH_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PH_HIGH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TDS_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TEMP_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TEMP_HIGH  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BATT_LOW   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SIGNAL_LIM = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MANUAL     = 3'd7;

  // Register reset values.
  localparam logic signed [31:0] PH_LOW_RST     = 32'sd393216;
  localparam logic signed [31:0] PH_HIGH_RST    = 32'sd557056;
  localparam logic signed [31:0] TDS_HIGH_RST   = 32'sd32768000;
  localparam logic signed [31:0] TEMP_LOW_RST   = 32'sd0;
  localparam logic signed [31:0] TEMP_HIGH_RST  = 32'sd2293760;
  localparam logic [22:0]        BATT_LOW_RST   = 23'd1310720;
  localparam logic signed [7:0]  SIGNAL_LIM_RST = -8'sd100;

  // Alarm types.
  localparam logic [1:0] ALARM_WATER   = 2'd0;
  localparam logic [1:0] ALARM_BATTERY = 2'd1;
  localparam logic [1:0] ALARM_SIGNAL  = 2'd2;

  // Alarm levels.
  localparam logic [1:0] LEVEL_NORMAL   = 2'd0;
  localparam logic [1:0] LEVEL_SERIOUS  = 2'd1;
  localparam logic [1:0] LEVEL_CRITICAL = 2'd2;

  // Failure counts that raise the water alarm level.
  localparam logic [1:0] CRIT_FAILS = 2'd3;
  localparam logic [1:0] SER_FAILS  = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] ph_value;
    logic signed [31:0] tds_value;
    logic signed [31:0] temp_value;
    logic [22:0]        battery_level;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        mute_ticks;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]         alarm_class;
    logic [1:0]         severity;
    logic [31:0]        alarm_number;
    logic signed [31:0] measured_value;
    logic signed [31:0] limit_value;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic signed [31:0] ph_low_limit;
    logic signed [31:0] ph_high_limit;
    logic signed [31:0] tds_high_limit;
    logic signed [31:0] temp_low_limit;
    logic signed [31:0] temp_high_limit;
    logic [22:0]        battery_low_limit;
    logic signed [7:0]  signal_weak_limit;
    logic               manual_mode;
  } cfg_regs_t;

  // Outcome of the threshold checks for one sample.
  typedef struct packed {
    logic               raise;
    logic [1:0]         alarm_class;
    logic [1:0]         severity;
    logic signed [31:0] measured_value;
    logic signed [31:0] limit_value;
  } check_res_t;

endpackage

>>> rtl/sta_cfg.sv
// Configuration register file of the sensor threshold alarm.
`timescale 1ns / 1ps

module sta_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sta_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  output sta_pkg::cfg_regs_t            regs
);

  sta_pkg::cfg_regs_t regs_r;
  logic               wr_en;

  // Writes never stall, so the port is always ready.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid & cfg_ready;
  assign regs      = regs_r;

  // Register writes decoded by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.ph_low_limit      <= sta_pkg::PH_LOW_RST;
      regs_r.ph_high_limit     <= sta_pkg::PH_HIGH_RST;
      regs_r.tds_high_limit    <= sta_pkg::TDS_HIGH_RST;
      regs_r.temp_low_limit    <= sta_pkg::TEMP_LOW_RST;
      regs_r.temp_high_limit   <= sta_pkg::TEMP_HIGH_RST;
      regs_r.battery_low_limit <= sta_pkg::BATT_LOW_RST;
      regs_r.signal_weak_limit <= sta_pkg::SIGNAL_LIM_RST;
      regs_r.manual_mode       <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_index)
        sta_pkg::REG_PH_LOW:     regs_r.ph_low_limit      <= cfg_data;
        sta_pkg::REG_PH_HIGH:    regs_r.ph_high_limit     <= cfg_data;
        sta_pkg::REG_TDS_HIGH:   regs_r.tds_high_limit    <= cfg_data;
        sta_pkg::REG_TEMP_LOW:   regs_r.temp_low_limit    <= cfg_data;
        sta_pkg::REG_TEMP_HIGH:  regs_r.temp_high_limit   <= cfg_data;
        sta_pkg::REG_BATT_LOW:   regs_r.battery_low_limit <= cfg_data[22:0];
        sta_pkg::REG_SIGNAL_LIM: regs_r.signal_weak_limit <= cfg_data[7:0];
        sta_pkg::REG_MANUAL:     regs_r.manual_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sta_check.sv
// Threshold checks and worst-value selection for one sensor sample.
`timescale 1ns / 1ps

module sta_check (
  input  sta_pkg::in_item_t    item,
  input  sta_pkg::cfg_regs_t   regs,
  output sta_pkg::check_res_t  res
);

  logic       ph_low_fail, ph_high_fail, ph_fail;
  logic       tds_fail, tds_take;
  logic       temp_low_fail, temp_high_fail, temp_fail;
  logic       water_fail, batt_fail, sig_fail;
  logic [1:0] fails;
  logic [1:0] water_level;
  logic signed [31:0] ph_thr, temp_thr;
  logic signed [31:0] water_val, water_thr;

  // Individual window and limit comparisons.
  assign ph_low_fail    = item.ph_value < regs.ph_low_limit;
  assign ph_high_fail   = !ph_low_fail && (item.ph_value > regs.ph_high_limit);
  assign ph_fail        = ph_low_fail | ph_high_fail;
  assign ph_thr         = ph_low_fail ? regs.ph_low_limit : regs.ph_high_limit;
  assign tds_fail       = item.tds_value > regs.tds_high_limit;
  assign temp_low_fail  = item.temp_value < regs.temp_low_limit;
  assign temp_high_fail = !temp_low_fail && (item.temp_value > regs.temp_high_limit);
  assign temp_fail      = temp_low_fail | temp_high_fail;
  assign temp_thr       = temp_low_fail ? regs.temp_low_limit : regs.temp_high_limit;

  // TDS replaces a pH pick only when it is larger; it always wins when alone so far.
  assign tds_take = tds_fail && (!ph_fail || (item.tds_value > item.ph_value));

  assign fails = {1'b0, ph_fail} + {1'b0, tds_fail} + {1'b0, temp_fail};
  assign water_fail = ph_fail | tds_fail | temp_fail;

  // Level from the failure count.
  always_comb begin
    if (fails >= sta_pkg::CRIT_FAILS) begin
      water_level = sta_pkg::LEVEL_CRITICAL;
    end else if (fails >= sta_pkg::SER_FAILS) begin
      water_level = sta_pkg::LEVEL_SERIOUS;
    end else begin
      water_level = sta_pkg::LEVEL_NORMAL;
    end
  end

  // Worst value pick: temperature last, so it overrides the others.
  always_comb begin
    water_val = item.ph_value;
    water_thr = ph_thr;
    if (tds_take) begin
      water_val = item.tds_value;
      water_thr = regs.tds_high_limit;
    end
    if (temp_fail) begin
      water_val = item.temp_value;
      water_thr = temp_thr;
    end
  end

  assign batt_fail = item.battery_level < regs.battery_low_limit;
  assign sig_fail  = (item.signal_dbm < regs.signal_weak_limit) && (item.signal_dbm != 8'sd0);

  // Priority: water checks, then battery, then signal.
  always_comb begin
    res.raise          = 1'b0;
    res.alarm_class    = sta_pkg::ALARM_WATER;
    res.severity       = water_level;
    res.measured_value = water_val;
    res.limit_value    = water_thr;
    if (water_fail) begin
      res.raise = 1'b1;
    end else if (batt_fail) begin
      res.raise          = 1'b1;
      res.alarm_class    = sta_pkg::ALARM_BATTERY;
      res.severity       = sta_pkg::LEVEL_SERIOUS;
      res.measured_value = {9'd0, item.battery_level};
      res.limit_value    = {9'd0, regs.battery_low_limit};
    end else if (sig_fail) begin
      res.raise          = 1'b1;
      res.alarm_class    = sta_pkg::ALARM_SIGNAL;
      res.severity       = sta_pkg::LEVEL_NORMAL;
      res.measured_value = {{8{item.signal_dbm[7]}}, item.signal_dbm, 16'd0};
      res.limit_value    = {{8{regs.signal_weak_limit[7]}}, regs.signal_weak_limit, 16'd0};
    end
  end

endmodule

>>> rtl/sensor_threshold_alarm.sv
// Top level of the sensor threshold alarm: state, result register and handshakes.
// A sample that raises an alarm shows on out_valid in the cycle after acceptance.
// One transaction per cycle unless stalled; checks sit between the input port and result register.
// in_stall is high only while the result register holds an alarm that out_stall blocks.
// Reset (synchronous, rst_n low) loads the default limits and clears mute and sequence count.
`timescale 1ns / 1ps

module sensor_threshold_alarm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sta_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sta_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sta_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);

  sta_pkg::cfg_regs_t  regs;
  sta_pkg::check_res_t chk;
  sta_pkg::out_item_t  out_data_r;
  logic                out_valid_r;
  logic [31:0]         mute_r, mute_nxt;
  logic [31:0]         count_r, count_nxt;
  logic                in_fire, suppressed, load;

  sta_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  sta_check u_check (
    .item (in_data),
    .regs (regs),
    .res  (chk)
  );

  // Input is held off only when a finished alarm cannot leave.
  assign in_stall   = out_valid_r & out_stall;
  assign in_fire    = in_valid & !in_stall;
  assign suppressed = regs.manual_mode | (mute_r != 32'd0);
  assign load       = in_fire && (in_data.kind == sta_pkg::KIND_SAMPLE) && !suppressed
                      && chk.raise;

  // Mute countdown and sequence number updates.
  always_comb begin
    mute_nxt  = mute_r;
    count_nxt = count_r;
    if (in_fire) begin
      case (in_data.kind)
        sta_pkg::KIND_TICK: begin
          if (mute_r != 32'd0) mute_nxt = mute_r - 32'd1;
        end
        sta_pkg::KIND_MUTE: begin
          if (in_data.mute_ticks != 32'd0) mute_nxt = in_data.mute_ticks;
        end
        sta_pkg::KIND_SAMPLE: begin
          if (load) count_nxt = count_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r  <= 32'd0;
      count_r <= 32'd0;
    end else begin
      mute_r  <= mute_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register: loads a new alarm, drains when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.alarm_class    <= chk.alarm_class;
      out_data_r.severity       <= chk.severity;
      out_data_r.alarm_number   <= count_nxt;
      out_data_r.measured_value <= chk.measured_value;
      out_data_r.limit_value    <= chk.limit_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A loaded alarm carries the updated sequence number.
  a_number_matches: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && (out_data_r.alarm_number == count_r))
    else $error("alarm number differs from sequence count");

  // The sequence count moves only with an emitted alarm.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> count_r == $past(count_r))
    else $error("sequence count changed without an alarm");

  // An active mute blocks every alarm.
  a_mute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (mute_r != 32'd0) |-> !load)
    else $error("alarm raised while muted");

  // A new alarm never overwrites one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !load)
    else $error("held alarm overwritten");

endmodule
